// ===== design/bvm_pkg.sv =====
package bvm_pkg;

  localparam int VOICE_COUNT      = 32;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SINE_POS_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_ADDR_W = SINE_POS_W + 1;
  localparam int ACC_W       = 26;
  localparam int MAG_W       = 22;
  localparam int RATE_W      = 18;
  localparam int DIVIDEND_W  = MAG_W + 24;

  localparam logic [23:0] CARRIER_MIN_Q8 = 24'd5120;
  localparam logic [23:0] CARRIER_MAX_Q8 = 24'd2560000;
  localparam int          BEAT_LIM_Q8    = 25600;
  localparam logic [15:0] UNIT_Q15       = 16'd32768;
  localparam logic [15:0] VOL_EPS_Q15    = 16'd3;
  localparam logic [15:0] HARM_EPS_Q15   = 16'd327;
  localparam int          GLIDE_Q16      = 3277;
  localparam int          HARM_WEIGHT    = 4915;
  localparam logic [RATE_W-1:0] DEFAULT_RATE = 18'd48000;
  localparam int          OUT_MAX        = 8388607;
  localparam int          OUT_MIN        = -8388608;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_STOP = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_WR,
    ST_SCAN,
    ST_GLIDE,
    ST_SINE,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_C,
    ST_DIV_L,
    ST_DIV_R,
    ST_VWR,
    ST_DONE
  } engine_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         voice_index;
    logic [23:0]        carrier_hz_q8;
    logic signed [23:0] beat_hz_q8;
    logic [15:0]        volume_q15;
    logic [15:0]        harmonic_q15;
    logic [15:0]        pan_q15;
  } request_t;

  typedef struct packed {
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
  } result_t;

  typedef struct packed {
    logic [23:0]        carrier;
    logic signed [15:0] beat;
    logic [15:0]        volume;
    logic [15:0]        harmonic;
    logic [15:0]        pan;
  } voice_params_t;

  typedef struct packed {
    logic [31:0]   phase_left;
    logic [31:0]   phase_right;
    voice_params_t cur;
    voice_params_t tgt;
  } voice_word_t;

  localparam voice_params_t PARAMS_RESET = '{
    carrier: 24'd0, beat: 16'sd0, volume: 16'd0, harmonic: 16'd0, pan: 16'd16384
  };

  localparam voice_word_t VOICE_RESET = '{
    phase_left: 32'd0, phase_right: 32'd0, cur: PARAMS_RESET, tgt: PARAMS_RESET
  };

  typedef logic [14:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x  = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[i] = s[14:0];
    end
    return tab;
  endfunction

endpackage

// ===== design/bvm_sine_rom.sv =====
module bvm_sine_rom (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [16:0] value
);

  localparam bvm_pkg::sine_tab_t TAB = bvm_pkg::build_sine();

  logic [1:0]                      quad;
  logic [bvm_pkg::SINE_POS_W-1:0]  pos;
  logic [bvm_pkg::SINE_ADDR_W-1:0] addr;
  logic [14:0]                     rdata;
  logic                            neg;

  assign quad = phase[31:30];
  assign pos  = phase[29 -: bvm_pkg::SINE_POS_W];

  always_comb begin
    if (quad[0]) begin
      addr = bvm_pkg::SINE_ADDR_W'(bvm_pkg::SINE_TABLE_DEPTH) - {1'b0, pos};
    end else begin
      addr = {1'b0, pos};
    end
  end

  always_ff @(posedge clk) begin
    rdata <= TAB[addr];
    neg   <= quad[1];
  end

  assign value = neg ? -$signed({2'b00, rdata}) : $signed({2'b00, rdata});

endmodule

// ===== design/bvm_divider.sv =====
module bvm_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bvm_pkg::MAG_W-1:0]  mag,
  input  logic [bvm_pkg::RATE_W-1:0] divisor,
  output logic                       done,
  output logic [31:0]                quo
);

  localparam int CNT_W = $clog2(bvm_pkg::DIVIDEND_W);

  logic                             busy;
  logic [CNT_W-1:0]                 cnt;
  logic [bvm_pkg::DIVIDEND_W-1:0]   num;
  logic [bvm_pkg::RATE_W-1:0]       rem;
  logic [bvm_pkg::RATE_W-1:0]       dvs;
  logic [bvm_pkg::RATE_W:0]         trial;
  logic                             ge;

  assign trial = {rem, num[bvm_pkg::DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(bvm_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {mag, 24'd0};
      rem <= '0;
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      num <= {num[bvm_pkg::DIVIDEND_W-2:0], 1'b0};
      rem <= ge ? bvm_pkg::RATE_W'(trial - {1'b0, dvs}) : trial[bvm_pkg::RATE_W-1:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

// ===== design/bvm_engine.sv =====
module bvm_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bvm_pkg::request_t          req,
  input  logic [bvm_pkg::RATE_W-1:0] rate,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bvm_pkg::result_t           res
);

  localparam logic [bvm_pkg::VIDX_W-1:0] LAST = bvm_pkg::VIDX_W'(bvm_pkg::VOICE_COUNT - 1);
  localparam logic [11:0] GLIDE_C = 12'(bvm_pkg::GLIDE_Q16);

  bvm_pkg::engine_state_t state, state_next;
  bvm_pkg::request_t      req_q;

  bvm_pkg::voice_word_t mem [bvm_pkg::VOICE_COUNT];
  bvm_pkg::voice_word_t rdata_raw;
  bvm_pkg::voice_word_t rd_word;
  bvm_pkg::voice_word_t req_word;
  bvm_pkg::voice_word_t wk;
  bvm_pkg::voice_word_t wdata;
  logic [bvm_pkg::VOICE_COUNT-1:0] written;
  logic [bvm_pkg::VOICE_COUNT-1:0] active;
  logic [bvm_pkg::VIDX_W-1:0] raddr, raddr_q, waddr, v, in_addr;
  logic mem_re, mem_we;
  logic set_activate;

  logic [2:0]                step;
  logic signed [16:0]        sines [4];
  logic signed [16:0]        rom_out;
  logic [31:0]               rom_phase;
  logic                      harm_en;
  logic [27:0]               h;
  logic [30:0]               gain_l, gain_r;
  logic signed [17:0]        sum_l, sum_r;
  logic signed [45:0]        hp_l, hp_r;
  logic signed [49:0]        tp_l, tp_r;
  logic signed [bvm_pkg::ACC_W-1:0] acc_l, acc_r;

  logic                       div_start, div_done;
  logic [bvm_pkg::MAG_W-1:0]  div_mag, lmag, rmag;
  logic [31:0]                div_quo;
  logic signed [25:0]         fr;
  logic                       rneg;

  logic [23:0]        c_clamp;
  logic signed [15:0] b_clamp;
  logic [15:0]        v_clamp, h_clamp, p_clamp;

  function automatic logic signed [25:0] glide(input logic signed [25:0] cur,
                                               input logic signed [25:0] tgt);
    logic signed [26:0] d;
    logic [25:0]        mag;
    logic [37:0]        prod;
    logic [25:0]        s;
    d    = 27'(tgt) - 27'(cur);
    mag  = (d < 0) ? 26'(-d) : 26'(d);
    prod = 38'(mag) * 38'(GLIDE_C);
    s    = 26'(prod >> 16);
    if (s == 26'd0 && mag != 26'd0) begin
      s = 26'd1;
    end
    return (d < 0) ? cur - $signed(s) : cur + $signed(s);
  endfunction

  function automatic logic [15:0] clamp_q15(input logic [15:0] x);
    return (x > bvm_pkg::UNIT_Q15) ? bvm_pkg::UNIT_Q15 : x;
  endfunction

  function automatic logic signed [25:0] uext(input logic [23:0] x);
    return $signed({2'b00, x});
  endfunction

  assign in_addr = bvm_pkg::VIDX_W'(req.voice_index);

  // Voice state memory, one word per voice; unwritten entries read as reset.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_raw <= mem[raddr];
      raddr_q   <= raddr;
    end
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rd_word = written[raddr_q] ? rdata_raw : bvm_pkg::VOICE_RESET;

  always_comb begin
    c_clamp = (req_q.carrier_hz_q8 < bvm_pkg::CARRIER_MIN_Q8) ? bvm_pkg::CARRIER_MIN_Q8 :
              (req_q.carrier_hz_q8 > bvm_pkg::CARRIER_MAX_Q8) ? bvm_pkg::CARRIER_MAX_Q8 :
              req_q.carrier_hz_q8;
    if (req_q.beat_hz_q8 < -24'sd25600) begin
      b_clamp = -16'(bvm_pkg::BEAT_LIM_Q8);
    end else if (req_q.beat_hz_q8 > 24'sd25600) begin
      b_clamp = 16'(bvm_pkg::BEAT_LIM_Q8);
    end else begin
      b_clamp = 16'(req_q.beat_hz_q8);
    end
    v_clamp = clamp_q15(req_q.volume_q15);
    h_clamp = clamp_q15(req_q.harmonic_q15);
    p_clamp = clamp_q15(req_q.pan_q15);

    req_word     = rd_word;
    set_activate = 1'b0;
    if (req_q.req_type == bvm_pkg::REQ_SET) begin
      req_word.tgt.carrier  = c_clamp;
      req_word.tgt.beat     = b_clamp;
      req_word.tgt.volume   = v_clamp;
      req_word.tgt.harmonic = h_clamp;
      req_word.tgt.pan      = p_clamp;
      if (!active[raddr_q] && v_clamp > bvm_pkg::VOL_EPS_Q15) begin
        set_activate        = 1'b1;
        req_word.cur        = req_word.tgt;
        req_word.cur.volume = 16'd0;
      end
    end else begin
      req_word.tgt.volume = 16'd0;
    end
  end

  assign waddr = (state == bvm_pkg::ST_REQ_WR) ? raddr_q : v;
  assign wdata = (state == bvm_pkg::ST_REQ_WR) ? req_word : wk;

  always_comb begin
    case (step)
      3'd0:    rom_phase = wk.phase_left;
      3'd1:    rom_phase = wk.phase_right;
      3'd2:    rom_phase = {wk.phase_left[30:0], 1'b0};
      3'd3:    rom_phase = {wk.phase_right[30:0], 1'b0};
      default: rom_phase = wk.phase_left;
    endcase
  end

  bvm_sine_rom u_rom (
    .clk   (clk),
    .phase (rom_phase),
    .value (rom_out)
  );

  assign lmag = bvm_pkg::MAG_W'(wk.cur.carrier);
  assign fr   = uext(wk.cur.carrier) + 26'(wk.cur.beat);
  assign rneg = fr < 0;
  assign rmag = rneg ? bvm_pkg::MAG_W'(-fr) : bvm_pkg::MAG_W'(fr);

  bvm_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (div_mag),
    .divisor (rate),
    .done    (div_done),
    .quo     (div_quo)
  );

  assign hp_l = 46'(sines[2]) * $signed({18'd0, h});
  assign hp_r = 46'(sines[3]) * $signed({18'd0, h});
  assign tp_l = 50'(sum_l) * $signed({19'd0, gain_l});
  assign tp_r = 50'(sum_r) * $signed({19'd0, gain_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    raddr      = v;
    div_start  = 1'b0;
    div_mag    = lmag;
    res_valid  = 1'b0;
    case (state)
      bvm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req.req_type)
            bvm_pkg::REQ_SET, bvm_pkg::REQ_STOP: begin
              if (int'(req.voice_index) < bvm_pkg::VOICE_COUNT) begin
                mem_re     = 1'b1;
                raddr      = in_addr;
                state_next = bvm_pkg::ST_REQ_WR;
              end
            end
            bvm_pkg::REQ_TICK: state_next = bvm_pkg::ST_SCAN;
            default: state_next = bvm_pkg::ST_IDLE;
          endcase
        end
      end
      bvm_pkg::ST_REQ_WR: begin
        mem_we     = 1'b1;
        state_next = bvm_pkg::ST_IDLE;
      end
      bvm_pkg::ST_SCAN: begin
        if (active[v]) begin
          mem_re     = 1'b1;
          state_next = bvm_pkg::ST_GLIDE;
        end else if (v == LAST) begin
          state_next = bvm_pkg::ST_DONE;
        end
      end
      bvm_pkg::ST_GLIDE: state_next = bvm_pkg::ST_SINE;
      bvm_pkg::ST_SINE: begin
        if (step == 3'd4) begin
          state_next = bvm_pkg::ST_MIX_A;
        end
      end
      bvm_pkg::ST_MIX_A: state_next = bvm_pkg::ST_MIX_B;
      bvm_pkg::ST_MIX_B: state_next = bvm_pkg::ST_MIX_C;
      bvm_pkg::ST_MIX_C: begin
        div_start  = 1'b1;
        state_next = bvm_pkg::ST_DIV_L;
      end
      bvm_pkg::ST_DIV_L: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_mag    = rmag;
          state_next = bvm_pkg::ST_DIV_R;
        end
      end
      bvm_pkg::ST_DIV_R: begin
        if (div_done) begin
          state_next = bvm_pkg::ST_VWR;
        end
      end
      bvm_pkg::ST_VWR: begin
        mem_we     = 1'b1;
        state_next = (v == LAST) ? bvm_pkg::ST_DONE : bvm_pkg::ST_SCAN;
      end
      bvm_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bvm_pkg::ST_IDLE;
        end
      end
      default: state_next = bvm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      active  <= '0;
    end else begin
      if (mem_we) begin
        written[waddr] <= 1'b1;
      end
      if (state == bvm_pkg::ST_REQ_WR && set_activate) begin
        active[raddr_q] <= 1'b1;
      end
      if (state == bvm_pkg::ST_VWR && wk.tgt.volume <= bvm_pkg::VOL_EPS_Q15 &&
          wk.cur.volume <= bvm_pkg::VOL_EPS_Q15) begin
        active[v] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bvm_pkg::ST_IDLE: begin
        req_q <= req;
        v     <= '0;
        acc_l <= '0;
        acc_r <= '0;
      end
      bvm_pkg::ST_SCAN: begin
        if (!active[v] && v != LAST) begin
          v <= v + 1'b1;
        end
      end
      bvm_pkg::ST_GLIDE: begin
        wk.phase_left   <= rd_word.phase_left;
        wk.phase_right  <= rd_word.phase_right;
        wk.tgt          <= rd_word.tgt;
        wk.cur.carrier  <= 24'(glide(uext(rd_word.cur.carrier), uext(rd_word.tgt.carrier)));
        wk.cur.beat     <= 16'(glide(26'(rd_word.cur.beat), 26'(rd_word.tgt.beat)));
        wk.cur.volume   <= 16'(glide(uext({8'd0, rd_word.cur.volume}),
                                     uext({8'd0, rd_word.tgt.volume})));
        wk.cur.harmonic <= 16'(glide(uext({8'd0, rd_word.cur.harmonic}),
                                     uext({8'd0, rd_word.tgt.harmonic})));
        wk.cur.pan      <= 16'(glide(uext({8'd0, rd_word.cur.pan}),
                                     uext({8'd0, rd_word.tgt.pan})));
        step            <= 3'd0;
      end
      bvm_pkg::ST_SINE: begin
        step <= step + 3'd1;
        if (step != 3'd0) begin
          sines[2'(step - 3'd1)] <= rom_out;
        end
      end
      bvm_pkg::ST_MIX_A: begin
        harm_en <= wk.cur.harmonic > bvm_pkg::HARM_EPS_Q15;
        h       <= 28'(wk.cur.harmonic) * 28'(bvm_pkg::HARM_WEIGHT);
        gain_l  <= 31'(wk.cur.volume) * 31'(17'(bvm_pkg::UNIT_Q15) - 17'(wk.cur.pan));
        gain_r  <= 31'(wk.cur.volume) * 31'(wk.cur.pan);
      end
      bvm_pkg::ST_MIX_B: begin
        sum_l <= 18'(sines[0]) + (harm_en ? 18'(hp_l >>> 30) : 18'sd0);
        sum_r <= 18'(sines[1]) + (harm_en ? 18'(hp_r >>> 30) : 18'sd0);
      end
      bvm_pkg::ST_MIX_C: begin
        acc_l <= acc_l + bvm_pkg::ACC_W'(tp_l >>> 30);
        acc_r <= acc_r + bvm_pkg::ACC_W'(tp_r >>> 30);
      end
      bvm_pkg::ST_DIV_L: begin
        if (div_done) begin
          wk.phase_left <= wk.phase_left + div_quo;
        end
      end
      bvm_pkg::ST_DIV_R: begin
        if (div_done) begin
          wk.phase_right <= rneg ? wk.phase_right - div_quo : wk.phase_right + div_quo;
        end
      end
      bvm_pkg::ST_VWR: begin
        if (v != LAST) begin
          v <= v + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (acc_l > bvm_pkg::ACC_W'(bvm_pkg::OUT_MAX)) begin
      res.left_sample = 24'(bvm_pkg::OUT_MAX);
    end else if (acc_l < bvm_pkg::ACC_W'(bvm_pkg::OUT_MIN)) begin
      res.left_sample = 24'(bvm_pkg::OUT_MIN);
    end else begin
      res.left_sample = 24'(acc_l);
    end
    if (acc_r > bvm_pkg::ACC_W'(bvm_pkg::OUT_MAX)) begin
      res.right_sample = 24'(bvm_pkg::OUT_MAX);
    end else if (acc_r < bvm_pkg::ACC_W'(bvm_pkg::OUT_MIN)) begin
      res.right_sample = 24'(bvm_pkg::OUT_MIN);
    end else begin
      res.right_sample = 24'(acc_r);
    end
  end

  a_glide_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == bvm_pkg::ST_GLIDE) |-> $past(mem_re))
    else $error("glide stage entered without a memory read");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");

  a_writeback_active: assert property (@(posedge clk) disable iff (rst)
    (state == bvm_pkg::ST_VWR) |-> active[v])
    else $error("write-back of an idle voice");

endmodule

// ===== design/binaural_voice_bank_mixer.sv =====
// Bank of binaural voices mixed into one stereo frame per tick request.
// Input requests arrive on the s_* stream: tuser carries the request type
// (set, stop, tick) and tdata carries the voice index and its parameters.
// Each tick request yields one stereo frame on the m_* stream; set and stop
// requests yield nothing. The sample rate is written over the APB port.
// In a tick, each active voice is read from the voice memory, glided,
// looked up four times in the single-port sine table, mixed, and then
// needs two serial 46-step divisions for its phase increments before it
// is written back.
// Frames wait in an output register, so set and stop requests are still
// taken while the receiver stalls; a further tick completes but holds its
// frame until that register is free.
// Reset clears all voices to idle with their reset parameters at once and
// sets the sample rate to 48000; no clearing pass is needed.
module binaural_voice_bank_mixer (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // voice_index, carrier_hz_q8, beat_hz_q8, volume_q15, harmonic_q15, pan_q15
  input  logic [103:0] s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // left_sample, right_sample
  output logic [47:0]  m_tdata
);

  localparam logic ADDR_SAMPLE_RATE = 1'b0;

  logic [bvm_pkg::RATE_W-1:0] sample_rate_hz;
  logic [bvm_pkg::RATE_W-1:0] rate_eff;
  bvm_pkg::request_t          req;
  bvm_pkg::result_t           res;
  logic                       res_valid, res_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= bvm_pkg::DEFAULT_RATE;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_SAMPLE_RATE) begin
      sample_rate_hz <= pwdata[bvm_pkg::RATE_W-1:0];
    end
  end

  assign prdata   = (paddr[2] == ADDR_SAMPLE_RATE) ? 32'(sample_rate_hz) : 32'd0;
  assign rate_eff = (sample_rate_hz == '0) ? bvm_pkg::DEFAULT_RATE : sample_rate_hz;

  assign req.req_type      = s_tuser;
  assign req.voice_index   = s_tdata[4:0];
  assign req.carrier_hz_q8 = s_tdata[28:5];
  assign req.beat_hz_q8    = $signed(s_tdata[52:29]);
  assign req.volume_q15    = s_tdata[68:53];
  assign req.harmonic_q15  = s_tdata[84:69];
  assign req.pan_q15       = s_tdata[100:85];

  bvm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .rate      (rate_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.right_sample, res.left_sample};
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [2:0] ADDR_RATE = 3'd0;
  localparam int STALL_LIMIT = 20000;

  class voice_bank_model;
    int sine_q [0:bvm_pkg::SINE_TABLE_DEPTH];
    int unsigned rate;
    bit active [bvm_pkg::VOICE_COUNT];
    bit [31:0] ph_l [bvm_pkg::VOICE_COUNT];
    bit [31:0] ph_r [bvm_pkg::VOICE_COUNT];
    int cur_car [bvm_pkg::VOICE_COUNT];
    int cur_beat [bvm_pkg::VOICE_COUNT];
    int cur_vol [bvm_pkg::VOICE_COUNT];
    int cur_harm [bvm_pkg::VOICE_COUNT];
    int cur_pan [bvm_pkg::VOICE_COUNT];
    int tgt_car [bvm_pkg::VOICE_COUNT];
    int tgt_beat [bvm_pkg::VOICE_COUNT];
    int tgt_vol [bvm_pkg::VOICE_COUNT];
    int tgt_harm [bvm_pkg::VOICE_COUNT];
    int tgt_pan [bvm_pkg::VOICE_COUNT];
    bvm_pkg::result_t frames_due [$];
    int errors;
    int frames_seen;

    function new();
      longint unsigned x, x2, t, s;
      longint unsigned divs [6];
      divs = '{156, 110, 72, 42, 20, 6};
      for (int i = 0; i <= bvm_pkg::SINE_TABLE_DEPTH; i++) begin
        x = (64'd1686629713 * i) / bvm_pkg::SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
          t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[k];
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 32767) begin
          s = 32767;
        end
        sine_q[i] = int'(s);
      end
      rate = 48000;
      for (int v = 0; v < bvm_pkg::VOICE_COUNT; v++) begin
        active[v] = 0;
        ph_l[v] = 0;
        ph_r[v] = 0;
        cur_car[v] = 0; cur_beat[v] = 0; cur_vol[v] = 0; cur_harm[v] = 0; cur_pan[v] = 16384;
        tgt_car[v] = 0; tgt_beat[v] = 0; tgt_vol[v] = 0; tgt_harm[v] = 0; tgt_pan[v] = 16384;
      end
      errors = 0;
      frames_seen = 0;
    endfunction

    function int sine_at(bit [31:0] p);
      int pos;
      pos = int'(p[29:20]);
      case (p[31:30])
        2'd0: return sine_q[pos];
        2'd1: return sine_q[bvm_pkg::SINE_TABLE_DEPTH - pos];
        2'd2: return -sine_q[pos];
        default: return -sine_q[bvm_pkg::SINE_TABLE_DEPTH - pos];
      endcase
    endfunction

    function int glide(int c, int t);
      longint d, m, s;
      d = longint'(t) - c;
      m = d < 0 ? -d : d;
      s = (m * 3277) >>> 16;
      if (s == 0 && m != 0) begin
        s = 1;
      end
      return d < 0 ? int'(c - s) : int'(c + s);
    endfunction

    function bit [31:0] advance(bit [31:0] p, longint f);
      longint unsigned m;
      bit [31:0] inc;
      int unsigned r;
      r = (rate == 0) ? 48000 : rate;
      m = f < 0 ? -f : f;
      inc = 32'((m << 24) / r);
      return f < 0 ? p - inc : p + inc;
    endfunction

    function int clamp(longint val, longint lo, longint hi);
      return val < lo ? int'(lo) : (val > hi ? int'(hi) : int'(val));
    endfunction

    function void note_request(bvm_pkg::request_t r);
      int i;
      longint l, rr, sl, sr, h;
      i = int'(r.voice_index);
      case (r.req_type)
        bvm_pkg::REQ_SET: begin
          tgt_car[i] = clamp(r.carrier_hz_q8, 5120, 2560000);
          tgt_beat[i] = clamp(longint'($signed(r.beat_hz_q8)), -25600, 25600);
          tgt_vol[i] = clamp(r.volume_q15, 0, 32768);
          tgt_harm[i] = clamp(r.harmonic_q15, 0, 32768);
          tgt_pan[i] = clamp(r.pan_q15, 0, 32768);
          if (!active[i] && tgt_vol[i] > 3) begin
            active[i] = 1;
            cur_car[i] = tgt_car[i];
            cur_beat[i] = tgt_beat[i];
            cur_harm[i] = tgt_harm[i];
            cur_pan[i] = tgt_pan[i];
            cur_vol[i] = 0;
          end
        end
        bvm_pkg::REQ_STOP: tgt_vol[i] = 0;
        bvm_pkg::REQ_TICK: begin
          l = 0;
          rr = 0;
          for (int v = 0; v < bvm_pkg::VOICE_COUNT; v++) begin
            if (!active[v]) begin
              continue;
            end
            cur_car[v] = glide(cur_car[v], tgt_car[v]);
            cur_beat[v] = glide(cur_beat[v], tgt_beat[v]);
            cur_vol[v] = glide(cur_vol[v], tgt_vol[v]);
            cur_pan[v] = glide(cur_pan[v], tgt_pan[v]);
            cur_harm[v] = glide(cur_harm[v], tgt_harm[v]);
            sl = sine_at(ph_l[v]);
            sr = sine_at(ph_r[v]);
            if (cur_harm[v] > 327) begin
              h = longint'(4915) * cur_harm[v];
              sl += (longint'(sine_at(ph_l[v] << 1)) * h) >>> 30;
              sr += (longint'(sine_at(ph_r[v] << 1)) * h) >>> 30;
            end
            l += (sl * cur_vol[v] * (32768 - cur_pan[v])) >>> 30;
            rr += (sr * cur_vol[v] * cur_pan[v]) >>> 30;
            ph_l[v] = advance(ph_l[v], cur_car[v]);
            ph_r[v] = advance(ph_r[v], longint'(cur_car[v]) + cur_beat[v]);
            if (tgt_vol[v] <= 3 && cur_vol[v] <= 3) begin
              active[v] = 0;
            end
          end
          l = clamp(l, bvm_pkg::OUT_MIN, bvm_pkg::OUT_MAX);
          rr = clamp(rr, bvm_pkg::OUT_MIN, bvm_pkg::OUT_MAX);
          frames_due.push_back('{left_sample: l[23:0], right_sample: rr[23:0]});
        end
        default: ;
      endcase
    endfunction

    function void check_frame(logic [47:0] d);
      bvm_pkg::result_t e;
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("frame with none expected: %h", d);
        errors++;
        return;
      end
      e = frames_due.pop_front();
      if (d[23:0] !== e.left_sample) begin
        $error("left_sample expected %h actual %h", e.left_sample, d[23:0]);
        errors++;
      end
      if (d[47:24] !== e.right_sample) begin
        $error("right_sample expected %h actual %h", e.right_sample, d[47:24]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [103:0] s_tdata;
  logic [1:0] s_tuser;
  logic [47:0] m_tdata;

  voice_bank_model model = new();
  int send_idle_pct = 11;
  int recv_idle_pct = 76;
  int hold_left = 0;
  int stall_count = 0;
  int n_req = 0;
  int cfg_errors = 0;

  binaural_voice_bank_mixer u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        model.check_frame(m_tdata);
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  function automatic bvm_pkg::request_t mk(logic [1:0] rq, int idx, logic [23:0] car,
                                           logic [23:0] bt, logic [15:0] vol,
                                           logic [15:0] harm, logic [15:0] pan);
    bvm_pkg::request_t r;
    r.req_type = rq;
    r.voice_index = idx[4:0];
    r.carrier_hz_q8 = car;
    r.beat_hz_q8 = bt;
    r.volume_q15 = vol;
    r.harmonic_q15 = harm;
    r.pan_q15 = pan;
    return r;
  endfunction

  function automatic bvm_pkg::request_t random_req();
    bvm_pkg::request_t r;
    int pick;
    logic [23:0] edges [4];
    edges = '{24'd0, 24'd5120, 24'd2560000, 24'hFFFFFF};
    pick = $urandom_range(99);
    r.req_type = pick < 40 ? bvm_pkg::REQ_SET : pick < 55 ? bvm_pkg::REQ_STOP :
                 pick < 95 ? bvm_pkg::REQ_TICK : REQ_NONE;
    r.voice_index = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    case ($urandom_range(3))
      0: r.carrier_hz_q8 = 24'($urandom);
      1: r.carrier_hz_q8 = 24'($urandom_range(2560000, 5120));
      2: r.carrier_hz_q8 = edges[$urandom_range(3)];
      default: r.carrier_hz_q8 = 24'($urandom_range(50000, 5120));
    endcase
    r.beat_hz_q8 = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(51200) - 25600);
    case ($urandom_range(2))
      0: r.volume_q15 = 16'($urandom);
      1: r.volume_q15 = 16'($urandom_range(32768));
      default: r.volume_q15 = 16'($urandom_range(8));
    endcase
    case ($urandom_range(2))
      0: r.harmonic_q15 = 16'($urandom);
      1: r.harmonic_q15 = 16'($urandom_range(400, 300));
      default: r.harmonic_q15 = 16'($urandom_range(32768));
    endcase
    r.pan_q15 = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(32768));
    return r;
  endfunction

  task automatic send_req(bvm_pkg::request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= r.req_type;
    s_tdata <= {3'b0, r.pan_q15, r.harmonic_q15, r.volume_q15, r.beat_hz_q8,
                r.carrier_hz_q8, r.voice_index};
    do @(posedge clk); while (!s_tready);
    model.note_request(r);
    n_req++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (model.frames_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rate(logic [17:0] val);
    logic [31:0] got;
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_RATE; pwdata <= 32'(val);
    @(posedge clk) penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 1; pwrite <= 0; penable <= 0;
    @(posedge clk) penable <= 1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 0; penable <= 0;
    if (got[17:0] !== val) begin
      $error("sample_rate_hz expected %0d actual %0d", val, got[17:0]);
      cfg_errors++;
    end
    model.rate = 32'(val);
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) send_req(random_req());
    drain();
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_req(mk(bvm_pkg::REQ_SET, 0, 24'd0, 24'h800000, 16'hFFFF, 16'hFFFF, 16'd0));
    send_req(mk(bvm_pkg::REQ_SET, 1, 24'hFFFFFF, 24'h7FFFFF, 16'd32768, 16'd328, 16'hFFFF));
    send_req(mk(bvm_pkg::REQ_SET, 2, 24'd5120, -24'sd25600, 16'd4, 16'd327, 16'd16384));
    send_req(mk(bvm_pkg::REQ_SET, 3, 24'd100000, 24'd0, 16'd3, 16'd0, 16'd32768));
    send_req(mk(bvm_pkg::REQ_TICK, 0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_TICK, 0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_SET, 0, 24'd2560000, 24'd25600, 16'd1000, 16'd0, 16'd32768));
    send_req(mk(bvm_pkg::REQ_STOP, 2, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(REQ_NONE, 1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (4) send_req(mk(bvm_pkg::REQ_TICK, 31, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_STOP, 31, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_SET, 31, 24'd20000, 24'd0, 16'd0, 16'd1000, 16'd0));
    send_req(mk(bvm_pkg::REQ_STOP, 0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_STOP, 1, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(bvm_pkg::REQ_TICK, 0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0));
    drain();

    write_rate(18'd262143);
    random_phase(330);
    send_idle_pct = 76;
    recv_idle_pct = 11;
    write_rate(18'd1);
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rate(18'd0);
    hold_left = 3000;
    random_phase(350);
    write_rate(18'd44100);
    random_phase(300);

    $display("Sent %0d requests and checked %0d stereo frames over five sample rates.",
             n_req, model.frames_seen);
    $display("Rates included zero, one and the 18-bit maximum, with a long output stall.");
    if (model.errors == 0 && cfg_errors == 0 && model.frames_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== binaural_voice_bank_mixer.f =====
design/bvm_pkg.sv
design/bvm_sine_rom.sv
design/bvm_divider.sv
design/bvm_engine.sv
design/binaural_voice_bank_mixer.sv
tb/tb.sv
